/* hdl/germ_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// germ_pkg
// Shared types, codes and remap tables for the gamepad event remapper.
// ----------------------------------------------------------------------------
package germ_pkg;

   // sizes
   localparam int AXIS_SLOTS  = 16;
   localparam int AXIS_IDX_W  = $clog2(AXIS_SLOTS);
   localparam int AXIS_W      = 16;
   localparam int BTN_W       = 18;
   localparam int BTN_IDX_W   = $clog2(BTN_W);
   localparam int SLOT_W      = 5;
   localparam int WORD_W      = 18;
   localparam int SNAP_WORDS  = AXIS_SLOTS + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic [1:0] OP_EVENT   = 2'd0;
   localparam logic [1:0] OP_PUBLISH = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   // event kinds
   localparam logic [7:0] KIND_BUTTON = 8'd1;
   localparam logic [7:0] KIND_AXIS   = 8'd2;

   // pad kinds
   localparam logic PAD_DIRECT = 1'b0;
   localparam logic PAD_REMAP  = 1'b1;

   // starting pressure, -32767
   localparam logic [AXIS_W-1:0] START_PRESSURE = 16'h8001;

   // last snapshot slot
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SNAP_WORDS - 1);

   typedef struct packed {
      logic [1:0]        op;
      logic [7:0]        event_kind;
      logic [7:0]        event_number;
      logic signed [15:0] event_value;
      logic [31:0]       event_time;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] word;
      logic              last;
   } rsp_type;

   // decoded command from front to back
   typedef struct packed {
      logic                  do_publish;
      logic                  do_read;
      logic [BTN_W-1:0]      btn_mask;
      logic [BTN_W-1:0]      btn_val;
      logic                  ax0_en;
      logic [AXIS_IDX_W-1:0] ax0_idx;
      logic [AXIS_W-1:0]     ax0_val;
      logic                  ax1_en;
      logic [AXIS_IDX_W-1:0] ax1_idx;
      logic [AXIS_W-1:0]     ax1_val;
   } cmd_type;

   // remapped pad: button number to mask bit
   function automatic logic [BTN_IDX_W-1:0] btn_map(input logic [3:0] num);
      logic [BTN_IDX_W-1:0] b;
      unique case (num)
         4'd0:    b = 5'd15;
         4'd1:    b = 5'd14;
         4'd2:    b = 5'd13;
         4'd3:    b = 5'd12;
         4'd4:    b = 5'd10;
         4'd5:    b = 5'd11;
         4'd6:    b = 5'd8;
         4'd7:    b = 5'd9;
         4'd8:    b = 5'd0;
         4'd9:    b = 5'd3;
         4'd10:   b = 5'd1;
         4'd11:   b = 5'd2;
         4'd12:   b = 5'd16;
         4'd13:   b = 5'd17;
         default: b = 5'd0;
      endcase
      return b;
   endfunction

   // remapped pad: axis number to slot
   function automatic logic [AXIS_IDX_W-1:0] axis_map(input logic [2:0] num);
      logic [AXIS_IDX_W-1:0] s;
      unique case (num)
         3'd0:    s = 4'd0;
         3'd1:    s = 4'd1;
         3'd2:    s = 4'd2;
         3'd3:    s = 4'd8;
         3'd4:    s = 4'd9;
         3'd5:    s = 4'd3;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

/* hdl/gamepad_event_remapper_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_event_remapper_unit
// Folds gamepad events into a button mask and axis table, publishes
// snapshots at burst boundaries and reads them out as 17 words.
// ----------------------------------------------------------------------------
// Events and publish transactions are taken at one per cycle while the queue
// has space: the front end decodes each into a command, a two-entry queue
// buffers it, and the back end applies it to the working state. A read
// transaction holds the back end while it streams the snapshot (button mask
// first, then the 16 axis slots, last set on slot 16) through a single response
// register, one word per cycle when the sink is ready; the front keeps taking
// transactions until the queue fills. Writing csr_wdata sets the pad mode and
// reloads the starting state in the same cycle; write it only while idle.
module gamepad_event_remapper_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire germ_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output germ_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata
);
   import germ_pkg::*;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_data;

   // decode front
   germ_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd_data  (push_data)
   );

   // command queue
   germ_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // state back end
   germ_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* hdl/germ_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// germ_front
// Accepts request transactions, tracks burst timestamps and decodes each
// event into button mask and axis slot updates for the back end.
// ----------------------------------------------------------------------------
module germ_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire germ_pkg::req_type req_data,
   input  wire logic             csr_we,
   input  wire logic             csr_wdata,
   output logic                  cmd_valid,
   input  wire logic             cmd_ready,
   output germ_pkg::cmd_type     cmd_data
);
   import germ_pkg::*;

   logic        pad_kind_ff;
   logic [31:0] prev_time_ff;
   logic        time_seen_ff;
   logic        accept;
   logic        nonzero;
   logic        neg;
   logic        pos;
   logic [7:0]  num;
   logic [BTN_IDX_W-1:0] mapped_bit;
   cmd_type     cmd;

   // the unused op is taken and dropped, so ready only follows queue space
   assign req_ready = cmd_ready;
   assign accept    = req_valid && cmd_ready;
   assign cmd_valid = req_valid && (req_data.op != OP_UNUSED);
   assign cmd_data  = cmd;

   assign num        = req_data.event_number;
   assign nonzero    = |req_data.event_value;
   assign neg        = req_data.event_value[AXIS_W-1];
   assign pos        = !neg && nonzero;
   assign mapped_bit = btn_map(num[3:0]);

   // event decode
   always_comb begin
      cmd = '0;
      unique case (req_data.op)
         OP_EVENT: begin
            cmd.do_publish = time_seen_ff && (req_data.event_time != prev_time_ff);
            if (req_data.event_kind == KIND_BUTTON) begin
               if (pad_kind_ff == PAD_DIRECT) begin
                  if (num < 8'd17) begin
                     cmd.btn_mask[num[BTN_IDX_W-1:0]] = 1'b1;
                     cmd.btn_val[num[BTN_IDX_W-1:0]]  = nonzero;
                  end
               end else if (num < 8'd14) begin
                  cmd.btn_mask[mapped_bit] = 1'b1;
                  cmd.btn_val[mapped_bit]  = nonzero;
                  // face and shoulder buttons also carry a pressure
                  if (num < 8'd12 && num != 8'd6 && num != 8'd7) begin
                     cmd.ax0_en  = 1'b1;
                     cmd.ax0_idx = mapped_bit[AXIS_IDX_W-1:0];
                     cmd.ax0_val = req_data.event_value;
                  end
               end
            end else if (req_data.event_kind == KIND_AXIS) begin
               if (pad_kind_ff == PAD_DIRECT) begin
                  if (num <= 8'd3) begin
                     cmd.ax0_en  = 1'b1;
                     cmd.ax0_idx = num[AXIS_IDX_W-1:0];
                     cmd.ax0_val = req_data.event_value;
                  end else if (num >= 8'd8 && num < 8'd20) begin
                     cmd.ax0_en  = 1'b1;
                     cmd.ax0_idx = 4'(num - 8'd4);
                     cmd.ax0_val = req_data.event_value;
                  end
               end else if (num == 8'd6) begin
                  // horizontal d-pad: left on bit 7, right on bit 5
                  cmd.btn_mask[7] = 1'b1;
                  cmd.btn_val[7]  = neg;
                  cmd.btn_mask[5] = 1'b1;
                  cmd.btn_val[5]  = pos;
                  cmd.ax0_en  = 1'b1;
                  cmd.ax0_idx = 4'd7;
                  cmd.ax0_val = AXIS_W'(neg);
                  cmd.ax1_en  = 1'b1;
                  cmd.ax1_idx = 4'd5;
                  cmd.ax1_val = AXIS_W'(pos);
               end else if (num == 8'd7) begin
                  // vertical d-pad: up on bit 4, down on bit 6
                  cmd.btn_mask[4] = 1'b1;
                  cmd.btn_val[4]  = neg;
                  cmd.btn_mask[6] = 1'b1;
                  cmd.btn_val[6]  = pos;
                  cmd.ax0_en  = 1'b1;
                  cmd.ax0_idx = 4'd4;
                  cmd.ax0_val = AXIS_W'(neg);
                  cmd.ax1_en  = 1'b1;
                  cmd.ax1_idx = 4'd6;
                  cmd.ax1_val = AXIS_W'(pos);
               end else if (num < 8'd6) begin
                  cmd.ax0_en  = 1'b1;
                  cmd.ax0_idx = axis_map(num[2:0]);
                  cmd.ax0_val = req_data.event_value;
               end
            end
         end
         OP_PUBLISH: cmd.do_publish = 1'b1;
         OP_READ:    cmd.do_read    = 1'b1;
         default:    cmd            = '0;
      endcase
   end

   // pad mode and burst timestamp tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         pad_kind_ff  <= PAD_DIRECT;
         prev_time_ff <= '0;
         time_seen_ff <= 1'b0;
      end else if (csr_we) begin
         pad_kind_ff  <= csr_wdata;
         prev_time_ff <= '0;
         time_seen_ff <= 1'b0;
      end else if (accept && req_data.op == OP_EVENT) begin
         prev_time_ff <= req_data.event_time;
         time_seen_ff <= 1'b1;
      end
   end

endmodule
`default_nettype wire

/* hdl/germ_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// germ_queue
// Short command queue between the decode front and the state back end.
// ----------------------------------------------------------------------------
module germ_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire germ_pkg::cmd_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output germ_pkg::cmd_type      pop_data
);
   import germ_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* hdl/germ_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// germ_back
// Holds working and published pad state, applies decoded commands and
// streams the published snapshot out through the response register.
// ----------------------------------------------------------------------------
module germ_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire germ_pkg::cmd_type cmd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output germ_pkg::rsp_type      rsp_data
);
   import germ_pkg::*;

   logic [BTN_W-1:0]  work_buttons_ff;
   logic [BTN_W-1:0]  work_buttons_in;
   logic [BTN_W-1:0]  pub_buttons_ff;
   logic [AXIS_W-1:0] work_axes_ff [AXIS_SLOTS];
   logic [AXIS_W-1:0] work_axes_in [AXIS_SLOTS];
   logic [AXIS_W-1:0] pub_axes_ff  [AXIS_SLOTS];
   logic [AXIS_W-1:0] start_axes   [AXIS_SLOTS];
   logic              rd_active_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic [SLOT_W-1:0] slot_less;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;
   logic              out_free;
   logic              cmd_fire;

   assign cmd_ready = !rd_active_ff;
   assign cmd_fire  = cmd_valid && cmd_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_less = rd_slot_ff - 1'b1;

   // working state after the command's updates
   always_comb begin
      work_buttons_in = (work_buttons_ff & ~cmd_data.btn_mask)
                        | (cmd_data.btn_val & cmd_data.btn_mask);
      for (int i = 0; i < AXIS_SLOTS; i++) begin
         work_axes_in[i] = work_axes_ff[i];
         if (cmd_data.ax0_en && cmd_data.ax0_idx == AXIS_IDX_W'(i)) begin
            work_axes_in[i] = cmd_data.ax0_val;
         end
         if (cmd_data.ax1_en && cmd_data.ax1_idx == AXIS_IDX_W'(i)) begin
            work_axes_in[i] = cmd_data.ax1_val;
         end
      end
   end

   // starting pressures for the mode being written
   always_comb begin
      for (int i = 0; i < AXIS_SLOTS; i++) begin
         if (csr_wdata == PAD_DIRECT) begin
            start_axes[i] = (i >= 4) ? START_PRESSURE : '0;
         end else begin
            start_axes[i] = (i == 8 || i == 9) ? START_PRESSURE : '0;
         end
      end
   end

   // snapshot word for the current read slot
   always_comb begin
      rsp_data_in.slot = rd_slot_ff;
      rsp_data_in.last = rd_slot_ff == LAST_SLOT;
      if (rd_slot_ff == '0) begin
         rsp_data_in.word = pub_buttons_ff;
      end else begin
         rsp_data_in.word = WORD_W'(pub_axes_ff[slot_less[AXIS_IDX_W-1:0]]);
      end
   end

   // pad state
   always_ff @(posedge clock) begin
      if (reset) begin
         work_buttons_ff <= '0;
         pub_buttons_ff  <= '0;
         for (int i = 0; i < AXIS_SLOTS; i++) begin
            work_axes_ff[i] <= '0;
            pub_axes_ff[i]  <= '0;
         end
      end else if (csr_we) begin
         work_buttons_ff <= '0;
         pub_buttons_ff  <= '0;
         for (int i = 0; i < AXIS_SLOTS; i++) begin
            work_axes_ff[i] <= start_axes[i];
            pub_axes_ff[i]  <= start_axes[i];
         end
      end else if (cmd_fire && !cmd_data.do_read) begin
         // publish sees the state before this event
         if (cmd_data.do_publish) begin
            pub_buttons_ff <= work_buttons_ff;
            for (int i = 0; i < AXIS_SLOTS; i++) begin
               pub_axes_ff[i] <= work_axes_ff[i];
            end
         end
         work_buttons_ff <= work_buttons_in;
         for (int i = 0; i < AXIS_SLOTS; i++) begin
            work_axes_ff[i] <= work_axes_in[i];
         end
      end
   end

   // snapshot read sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_active_ff <= 1'b0;
         rd_slot_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= rd_active_ff;
         end
         if (cmd_fire && cmd_data.do_read) begin
            rd_active_ff <= 1'b1;
            rd_slot_ff   <= '0;
         end else if (rd_active_ff && out_free) begin
            if (rd_slot_ff == LAST_SLOT) begin
               rd_active_ff <= 1'b0;
            end
            rd_slot_ff <= rd_slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_active_ff && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/germ_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// germ_checker
// Port-level checks on the snapshot response stream of the remapper.
// ----------------------------------------------------------------------------
module germ_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire germ_pkg::rsp_type rsp_data
);
   import germ_pkg::*;

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // last marks exactly the final slot
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.slot == LAST_SLOT)))
      else $error("last flag does not match slot");

   // snapshot words follow back to back in slot order
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=>
         rsp_valid && rsp_data.slot == $past(rsp_data.slot) + 1'b1)
      else $error("snapshot slot sequence broken");

   // axis words are 16 bits wide
   a_axis_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.slot != '0 |-> rsp_data.word[WORD_W-1:AXIS_W] == '0)
      else $error("axis word has upper bits set");

endmodule

bind gamepad_event_remapper_unit germ_checker u_checker (.*);
`default_nettype wire
